@@ hdl/tccw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the text console cursor writer.
// No dependencies.
package tccw_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 7;
  localparam int COLS_W  = 8;
  localparam int ROWS_W  = 7;
  localparam int TAB_W   = 5;
  localparam int ADDR_W  = 13;
  localparam int WORD_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int PROD_W  = COL_W + COLS_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 3;

  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(80);
  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(25);
  localparam logic [TAB_W-1:0]  TAB_RESET  = TAB_W'(8);
  localparam logic [COLS_W-1:0] COLS_LIMIT = COLS_W'(MAX_COLUMNS);
  localparam logic [ROWS_W-1:0] ROWS_LIMIT = ROWS_W'(MAX_ROWS);

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TAB     = CFG_IDX_W'(2);

  localparam logic REQ_PUT   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [BYTE_W-1:0] CH_TAB = BYTE_W'(9);
  localparam logic [BYTE_W-1:0] CH_LF  = BYTE_W'(10);
  localparam logic [BYTE_W-1:0] CH_CR  = BYTE_W'(13);

  typedef struct packed {
    logic [COLS_W-1:0] cols;
    logic [ROWS_W-1:0] rows;
    logic [TAB_W-1:0]  tab;
  } geom_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] cell_index;
    logic [WORD_W-1:0] cell_word;
    logic              scroll_up;
    logic              screen_cleared;
    logic [ADDR_W-1:0] cursor_position;
  } result_t;

endpackage

@@ hdl/tccw_cfg.sv @@
`timescale 1ns / 1ps
// Geometry registers; columns and rows are clamped to effective values, tab width is not.
// Depends on tccw_pkg.
module tccw_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tccw_pkg::CFG_DAT_W-1:0]  cfg_data,
  output tccw_pkg::geom_t                 geom
);
  import tccw_pkg::*;

  logic [COLS_W-1:0] columns;
  logic [ROWS_W-1:0] rows_on_screen;
  logic [TAB_W-1:0]  tab_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns        <= COLS_RESET;
      rows_on_screen <= ROWS_RESET;
      tab_width      <= TAB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS: columns        <= cfg_data[COLS_W-1:0];
        CFG_ROWS:    rows_on_screen <= cfg_data[ROWS_W-1:0];
        CFG_TAB:     tab_width      <= cfg_data[TAB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.cols = columns;
    if (columns == '0) geom.cols = COLS_W'(1);
    else if (columns > COLS_LIMIT) geom.cols = COLS_LIMIT;
    geom.rows = rows_on_screen;
    if (rows_on_screen == '0) geom.rows = ROWS_W'(1);
    else if (rows_on_screen > ROWS_LIMIT) geom.rows = ROWS_LIMIT;
    geom.tab = tab_width;
  end

endmodule

@@ hdl/tccw_step.sv @@
`timescale 1ns / 1ps
// Cursor move and cell write for one request: next cursor and result fields.
// Depends on tccw_pkg.
module tccw_step (
  input  tccw_pkg::geom_t                 geom,
  input  logic                            req_type,
  input  logic [tccw_pkg::BYTE_W-1:0]     char_code,
  input  logic [tccw_pkg::BYTE_W-1:0]     attribute,
  input  logic [tccw_pkg::COL_W-1:0]      col,
  input  logic [tccw_pkg::ROW_W-1:0]      row,
  output logic [tccw_pkg::COL_W-1:0]      col_next,
  output logic [tccw_pkg::ROW_W-1:0]      row_next,
  output tccw_pkg::result_t               res
);
  import tccw_pkg::*;

  logic [COLS_W-1:0] c;
  logic [COLS_W-1:0] r;
  logic [COLS_W-1:0] tab_sum;
  logic [COLS_W-1:0] tab_wrap;
  logic [COLS_W-1:0] col_inc;
  logic [PROD_W-1:0] wr_prod;
  logic [PROD_W-1:0] cur_prod;

  always_comb begin
    c = {1'b0, col};
    r = {1'b0, row};
    tab_sum = {1'b0, col} + COLS_W'(geom.tab);
    tab_wrap = tab_sum - geom.cols;
    col_inc = {1'b0, col} + COLS_W'(1);
    res.write_valid    = 1'b0;
    res.cell_word      = '0;
    res.scroll_up      = 1'b0;
    res.screen_cleared = 1'b0;
    if (req_type == REQ_CLEAR) begin
      c = '0;
      r = '0;
      res.screen_cleared = 1'b1;
    end else begin
      case (char_code)
        CH_LF: begin
          r = r + COLS_W'(1);
          c = '0;
        end
        CH_TAB: begin
          if (tab_sum >= geom.cols) begin
            r = r + COLS_W'(1);
            c = (tab_wrap >= geom.cols) ? '0 : tab_wrap;
          end else begin
            c = tab_sum;
          end
        end
        CH_CR: c = '0;
        default: begin
          res.write_valid = 1'b1;
          res.cell_word   = {attribute, char_code};
          if (col_inc >= geom.cols) begin
            c = '0;
            r = r + COLS_W'(1);
          end else begin
            c = col_inc;
          end
        end
      endcase
      if (r >= {1'b0, geom.rows}) begin
        res.scroll_up = 1'b1;
        r = {1'b0, geom.rows} - COLS_W'(1);
      end
    end
    col_next = c[COL_W-1:0];
    row_next = r[ROW_W-1:0];

    // both products are independent: old cursor for the write, new one for position
    wr_prod  = PROD_W'(row) * PROD_W'(geom.cols) + PROD_W'(col);
    cur_prod = PROD_W'(r[ROW_W-1:0]) * PROD_W'(geom.cols) + PROD_W'(c[COL_W-1:0]);

    res.cell_index      = res.write_valid ? wr_prod[ADDR_W-1:0] : '0;
    res.cursor_position = cur_prod[ADDR_W-1:0];
  end

endmodule

@@ hdl/text_console_cursor_writer_core.sv @@
`timescale 1ns / 1ps
// Top level of the text console cursor writer: input register, cursor state,
// result register. Depends on tccw_pkg, tccw_cfg, tccw_step.
//
// Takes one request per cycle while the output side is not stalled and returns
// exactly one result per request: each request is held in the input register,
// then passes through the cursor logic into the result register. The cursor
// column and row are updated in the same cycle as the result is formed, so
// consecutive requests run back to back; throughput is one transfer per clock
// while the output is not stalled. A put of a printable byte issues a cell
// write at row*columns+column; tab, line feed and carriage return only move
// the cursor; scroll_up asks the display side to move the screen up one line.
// Geometry registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle; the block does not enforce it.
module text_console_cursor_writer_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tccw_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tccw_pkg::IN_DATA_W-1:0]     s_tdata,   // char_code[7:0], attribute[15:8]
  input  logic [0:0]                         s_tuser,   // req_type[0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tccw_pkg::OUT_DATA_W-1:0]    m_tdata,   // cell_index[12:0], cell_word[28:13],
                                                        // cursor_position[41:29], zero[47:42]
  output logic [tccw_pkg::OUT_USER_W-1:0]    m_tuser    // write_valid[0], scroll_up[1],
                                                        // screen_cleared[2]
);
  import tccw_pkg::*;

  geom_t             geom;
  logic              in_valid;
  logic              in_req;
  logic [BYTE_W-1:0] in_char;
  logic [BYTE_W-1:0] in_attr;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_column_next;
  logic [ROW_W-1:0]  cursor_row_next;
  result_t           res_next;
  result_t           res;
  logic              advance;

  tccw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  tccw_step u_step (
    .geom      (geom),
    .req_type  (in_req),
    .char_code (in_char),
    .attribute (in_attr),
    .col       (cursor_column),
    .row       (cursor_row),
    .col_next  (cursor_column_next),
    .row_next  (cursor_row_next),
    .res       (res_next)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req  <= s_tuser[0];
      in_char <= s_tdata[BYTE_W-1:0];
      in_attr <= s_tdata[2*BYTE_W-1:BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      cursor_column <= '0;
      cursor_row    <= '0;
    end else begin
      if (advance) begin
        m_tvalid      <= 1'b1;
        cursor_column <= cursor_column_next;
        cursor_row    <= cursor_row_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {(OUT_DATA_W - 2*ADDR_W - WORD_W)'(0),
                    res.cursor_position, res.cell_word, res.cell_index};
  assign m_tuser = {res.screen_cleared, res.scroll_up, res.write_valid};

endmodule
